>>> src/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg - shared definitions for the radial flow rate averager
// Widths, register indexes, limits and the compare-subtract result type.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

    localparam int MAX_POINTS = 128;
    localparam int COUNT_CAP  = (MAX_POINTS > 255) ? 255 : MAX_POINTS;

    localparam int CFG_W   = 12;
    localparam int UNIT_W  = 36;

    localparam logic [7:0] COUNT_CAP_V = 8'(COUNT_CAP);

    // configuration register indexes
    localparam logic REG_REGION_WIDTH  = 1'b0;
    localparam logic REG_REGION_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] REGION_RESET = 12'd64;

    // last step indexes of the shared unit and the multiplier
    localparam logic [5:0] SQRT_LAST     = 6'd16;  // 17 root bits
    localparam logic [5:0] ITEM_DIV_LAST = 6'd23;  // 24 quotient bits
    localparam logic [5:0] RATE_DIV_LAST = 6'd31;  // 32 quotient bits
    localparam logic [5:0] RAD_DIV_LAST  = 6'd23;  // 24 quotient bits
    localparam logic [2:0] MUL_LAST      = 3'd4;

    localparam logic [23:0] RATE_POS_MAX = 24'h7F_FFFF;
    localparam logic [23:0] RATE_NEG_MIN = 24'h80_0000;
    localparam logic [31:0] RATE_NEG_LIM = 32'h0080_0000;
    localparam logic [31:0] RATE_POS_LIM = 32'h007F_FFFF;
    localparam logic [31:0] SUM_POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] SUM_NEG_MIN  = 32'h8000_0000;
    localparam logic [23:0] RAD_SUM_MAX  = 24'hFF_FFFF;
    localparam logic [31:0] MEAN_RAD_LIM = 32'h0001_FFFF;
    localparam logic [16:0] MEAN_RAD_MAX = 17'h1_FFFF;

    typedef struct packed {
        logic              ge;    // minuend >= subtrahend
        logic [UNIT_W-1:0] diff;  // minuend - subtrahend
    } csub_res_t;

endpackage

`default_nettype wire

>>> src/rfr_csub.sv
// ----------------------------------------------------------------------------
// rfr_csub - shared compare-subtract unit
// One unsigned subtract with borrow; serves the root and divider steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_csub (
    input  wire logic [rfr_pkg::UNIT_W-1:0] minuend,
    input  wire logic [rfr_pkg::UNIT_W-1:0] subtrahend,
    output rfr_pkg::csub_res_t              res
);

    logic [rfr_pkg::UNIT_W:0] wide;

    assign wide     = {1'b0, minuend} - {1'b0, subtrahend};
    assign res.ge   = ~wide[rfr_pkg::UNIT_W];
    assign res.diff = wide[rfr_pkg::UNIT_W-1:0];

endmodule

`default_nettype wire

>>> src/radial_flow_rate_averager.sv
// ----------------------------------------------------------------------------
// radial_flow_rate_averager - per-frame mean radial rate and radius
// Accumulates radial rate and radius of tracked points, emits frame means.
// ----------------------------------------------------------------------------
// Input stream: one point per request. tdata = cur_x, cur_y, prev_x, prev_y
// (16 bits each, lowest first), tuser = tracked flag, tlast = last point of
// the frame. Output stream: one summary per frame, sent for the request that
// carries tlast. Config port: cfg_we/cfg_addr/cfg_wdata set region width and
// height (pixels); write only while the block is idle.
// Timing: a tracked point below the count cap holds s_axis_tready low while
// it is processed: four products on the single 18x18 multiplier, a 17-bit
// square root on the shared compare-subtract unit, a range check, a 24-bit
// rate division on the same unit, then the accumulate. A point on the centre
// skips the range check and the division, a clipped rate skips the division
// after the check. An untracked point that is not last is taken in idle.
// A last point adds the two mean divisions (32 and 24 quotient bits on the
// same unit) before the summary is offered; an empty frame skips them.
// One point is in work at a time; s_axis_tready is low meanwhile.
// The summary waits in an output register, so the next point is taken while
// the receiver stalls; the next summary waits for that register to drain.
// Reset (aresetn low, synchronous) clears sums and count, empties the output
// and sets width and height to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_flow_rate_averager (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [11:0] cfg_wdata,
    // input points
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // cur_x, cur_y, prev_x, prev_y
    input  wire logic        s_axis_tuser,   // tracked
    input  wire logic        s_axis_tlast,   // last point of frame
    // frame summaries
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // mean_rate, mean_radius, point_count
    output logic             m_axis_tuser    // empty_res
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DCHK,
        ST_DIV,
        ST_ACC,
        ST_SUM,
        ST_MRATE,
        ST_MRAD_LD,
        ST_MRAD,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [11:0]        width_reg, height_reg;
    logic signed [17:0] ox_reg, oy_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic               last_reg;
    logic signed [35:0] prod_reg;
    logic [33:0]        s_reg;
    logic signed [35:0] dot_reg;
    logic [33:0]        num_reg;
    logic [34:0]        rem_reg;
    logic [33:0]        div_reg;
    logic [31:0]        q_reg;
    logic [5:0]         step_reg;
    logic [16:0]        radius_reg;
    logic               neg_reg, sat_reg, empty_reg;
    logic signed [31:0] rate_sum_reg;
    logic [23:0]        radius_sum_reg;
    logic [7:0]         valid_count_reg;
    logic [23:0]        mrate_reg;
    logic               m_valid_reg, m_empty_reg;
    logic [23:0]        m_rate_reg;
    logic [16:0]        m_rad_reg;
    logic [7:0]         m_cnt_reg;

    logic                        accept;
    logic [17:0]                 in_ox, in_oy;
    logic [16:0]                 in_dx, in_dy;
    logic [rfr_pkg::UNIT_W-1:0]  cs_a, cs_b;
    rfr_pkg::csub_res_t          cs;
    logic signed [17:0]          mul_a, mul_b;
    logic signed [35:0]          mul_p;
    logic [35:0]                 dot_abs;
    logic [33:0]                 dot_mag;
    logic                        rate_sat;
    logic [23:0]                 item_q, item_rate;
    logic [32:0]                 rsum_wide;
    logic [31:0]                 rsum_next;
    logic [24:0]                 dsum_wide;
    logic [23:0]                 dsum_next;
    logic [31:0]                 rate_abs, q_neg;
    logic [23:0]                 mean_rate_v;
    logic [16:0]                 mean_rad_v;
    logic                        out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign in_ox = {2'b00, s_axis_tdata[15:0]}  - {3'b000, width_reg, 3'b000};
    assign in_oy = {2'b00, s_axis_tdata[31:16]} - {3'b000, height_reg, 3'b000};
    assign in_dx = {1'b0, s_axis_tdata[15:0]}  - {1'b0, s_axis_tdata[47:32]};
    assign in_dy = {1'b0, s_axis_tdata[31:16]} - {1'b0, s_axis_tdata[63:48]};

    // shared compare-subtract: root trial in ST_SQRT, divisor otherwise
    always_comb begin
        if (state_reg == ST_SQRT) begin
            cs_a = {rem_reg[33:0], num_reg[33:32]};
            cs_b = {17'd0, q_reg[16:0], 2'b01};
        end else begin
            cs_a = {rem_reg, num_reg[33]};
            cs_b = {2'b00, div_reg};
        end
    end

    rfr_csub u_csub (
        .minuend    (cs_a),
        .subtrahend (cs_b),
        .res        (cs)
    );

    // single multiplier: ox*ox, oy*oy, ox*dx, oy*dy in turn
    always_comb begin
        unique case (step_reg[1:0])
            2'd0: begin
                mul_a = ox_reg;
                mul_b = ox_reg;
            end
            2'd1: begin
                mul_a = oy_reg;
                mul_b = oy_reg;
            end
            2'd2: begin
                mul_a = ox_reg;
                mul_b = 18'(dx_reg);
            end
            default: begin
                mul_a = oy_reg;
                mul_b = 18'(dy_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dot_abs  = dot_reg[35] ? 36'(-dot_reg) : 36'(dot_reg);
    assign dot_mag  = dot_abs[33:0];
    // quotient would reach 2^24: clamp without dividing
    assign rate_sat = {8'd0, dot_mag} >= {s_reg, 8'd0};

    assign item_q = q_reg[23:0];
    always_comb begin
        if (sat_reg) begin
            item_rate = neg_reg ? rfr_pkg::RATE_NEG_MIN : rfr_pkg::RATE_POS_MAX;
        end else if (neg_reg) begin
            item_rate = (item_q > rfr_pkg::RATE_NEG_MIN) ? rfr_pkg::RATE_NEG_MIN
                                                         : 24'(24'd0 - item_q);
        end else begin
            item_rate = (item_q > rfr_pkg::RATE_POS_MAX) ? rfr_pkg::RATE_POS_MAX
                                                         : item_q;
        end
    end

    assign rsum_wide = {rate_sum_reg[31], rate_sum_reg} + {{9{item_rate[23]}}, item_rate};
    always_comb begin
        if (rsum_wide[32] != rsum_wide[31]) begin
            rsum_next = rsum_wide[32] ? rfr_pkg::SUM_NEG_MIN : rfr_pkg::SUM_POS_MAX;
        end else begin
            rsum_next = rsum_wide[31:0];
        end
    end

    assign dsum_wide = {1'b0, radius_sum_reg} + {8'd0, radius_reg};
    assign dsum_next = dsum_wide[24] ? rfr_pkg::RAD_SUM_MAX : dsum_wide[23:0];

    assign rate_abs = rate_sum_reg[31] ? 32'(-rate_sum_reg) : 32'(rate_sum_reg);
    assign q_neg    = 32'd0 - q_reg;

    always_comb begin
        if (neg_reg) begin
            mean_rate_v = (q_reg > rfr_pkg::RATE_NEG_LIM) ? rfr_pkg::RATE_NEG_MIN
                                                          : q_neg[23:0];
        end else begin
            mean_rate_v = (q_reg > rfr_pkg::RATE_POS_LIM) ? rfr_pkg::RATE_POS_MAX
                                                          : q_reg[23:0];
        end
    end

    assign mean_rad_v = (q_reg > rfr_pkg::MEAN_RAD_LIM) ? rfr_pkg::MEAN_RAD_MAX
                                                        : q_reg[16:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rfr_pkg::REGION_RESET;
            height_reg <= rfr_pkg::REGION_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rfr_pkg::REG_REGION_WIDTH:  width_reg  <= cfg_wdata;
                rfr_pkg::REG_REGION_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ox_reg   <= in_ox;
                    oy_reg   <= in_oy;
                    dx_reg   <= in_dx;
                    dy_reg   <= in_dy;
                    last_reg <= s_axis_tlast;
                end
            end
            ST_MUL: begin
                prod_reg <= mul_p;
                unique case (step_reg[2:0])
                    3'd1: s_reg <= prod_reg[33:0];
                    3'd2: s_reg <= s_reg + prod_reg[33:0];
                    3'd3: dot_reg <= prod_reg;
                    3'd4: begin
                        dot_reg <= dot_reg + prod_reg;
                        rem_reg <= '0;
                        num_reg <= s_reg;
                        q_reg   <= '0;
                    end
                    default: ;
                endcase
            end
            ST_SQRT: begin
                rem_reg <= cs.ge ? cs.diff[34:0] : cs_a[34:0];
                num_reg <= {num_reg[31:0], 2'b00};
                // point on the centre: rate forced to zero
                if (step_reg == rfr_pkg::SQRT_LAST && s_reg == '0) begin
                    q_reg   <= '0;
                    sat_reg <= 1'b0;
                end else begin
                    q_reg   <= {q_reg[30:0], cs.ge};
                end
                if (step_reg == rfr_pkg::SQRT_LAST) begin
                    radius_reg <= {q_reg[15:0], cs.ge};
                end
            end
            ST_DCHK: begin
                neg_reg <= dot_reg[35];
                sat_reg <= rate_sat;
                rem_reg <= {9'd0, dot_mag[33:8]};
                num_reg <= {dot_mag[7:0], 26'd0};
                div_reg <= s_reg;
                q_reg   <= '0;
            end
            ST_DIV, ST_MRATE, ST_MRAD: begin
                rem_reg <= cs.ge ? cs.diff[34:0] : cs_a[34:0];
                q_reg   <= {q_reg[30:0], cs.ge};
                num_reg <= {num_reg[32:0], 1'b0};
            end
            ST_SUM: begin
                empty_reg <= (valid_count_reg == '0);
                neg_reg   <= rate_sum_reg[31];
                rem_reg   <= '0;
                num_reg   <= {rate_abs, 2'b00};
                div_reg   <= {26'd0, valid_count_reg};
                q_reg     <= '0;
            end
            ST_MRAD_LD: begin
                mrate_reg <= mean_rate_v;
                rem_reg   <= '0;
                num_reg   <= {radius_sum_reg, 10'd0};
                q_reg     <= '0;
            end
            default: ;
        endcase
    end

    // sequencer, accumulators and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            rate_sum_reg    <= '0;
            radius_sum_reg  <= '0;
            valid_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (accept) begin
                        if (s_axis_tuser && valid_count_reg < rfr_pkg::COUNT_CAP_V) begin
                            state_reg <= ST_MUL;
                        end else if (s_axis_tlast) begin
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_MUL: begin
                    if (step_reg[2:0] == rfr_pkg::MUL_LAST) begin
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_SQRT: begin
                    if (step_reg == rfr_pkg::SQRT_LAST) begin
                        step_reg  <= '0;
                        state_reg <= (s_reg == '0) ? ST_ACC : ST_DCHK;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_DCHK: begin
                    step_reg  <= '0;
                    state_reg <= rate_sat ? ST_ACC : ST_DIV;
                end
                ST_DIV: begin
                    if (step_reg == rfr_pkg::ITEM_DIV_LAST) begin
                        step_reg  <= '0;
                        state_reg <= ST_ACC;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_ACC: begin
                    rate_sum_reg    <= rsum_next;
                    radius_sum_reg  <= dsum_next;
                    valid_count_reg <= valid_count_reg + 8'd1;
                    state_reg       <= last_reg ? ST_SUM : ST_IDLE;
                end
                ST_SUM: begin
                    step_reg  <= '0;
                    state_reg <= (valid_count_reg == '0) ? ST_OUT : ST_MRATE;
                end
                ST_MRATE: begin
                    if (step_reg == rfr_pkg::RATE_DIV_LAST) begin
                        step_reg  <= '0;
                        state_reg <= ST_MRAD_LD;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_MRAD_LD: begin
                    state_reg <= ST_MRAD;
                end
                ST_MRAD: begin
                    if (step_reg == rfr_pkg::RAD_DIV_LAST) begin
                        step_reg  <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (empty_reg) begin
                            m_rate_reg  <= '0;
                            m_rad_reg   <= '0;
                            m_cnt_reg   <= '0;
                            m_empty_reg <= 1'b1;
                        end else begin
                            m_rate_reg  <= mrate_reg;
                            m_rad_reg   <= mean_rad_v;
                            m_cnt_reg   <= valid_count_reg;
                            m_empty_reg <= 1'b0;
                        end
                        rate_sum_reg    <= '0;
                        radius_sum_reg  <= '0;
                        valid_count_reg <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_cnt_reg, m_rad_reg, m_rate_reg};
    assign m_axis_tuser  = m_empty_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_count_reg <= rfr_pkg::COUNT_CAP_V)
        else $error("point count above cap");

    a_clear_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (valid_count_reg == '0 && rate_sum_reg == '0
                                && radius_sum_reg == '0))
        else $error("sums not cleared with summary");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_cnt_reg == '0 && m_rate_reg == '0
                                          && m_rad_reg == '0))
        else $error("empty summary carries data");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_MRATE || state_reg == ST_MRAD)
        |-> (rem_reg < {1'b0, div_reg}))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
